FILE: rtl/bphr_pkg.sv
// ----------------------------------------------------------------------------
// bphr_pkg
// Shared constants and controller/datapath interface types for the button
// press / hold / repeat event generator.
// ----------------------------------------------------------------------------
package bphr_pkg;

  localparam int BUTTON_COUNT_DEF = 6;
  localparam int LEVEL_BITS       = 6;
  localparam int TIME_W           = 32;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int KIND_W           = 3;
  localparam int BTN_W            = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_THR_RST = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd100;

  // event kinds
  localparam logic [KIND_W-1:0] EV_PRESS     = 3'd0;
  localparam logic [KIND_W-1:0] EV_CLICK     = 3'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE   = 3'd2;
  localparam logic [KIND_W-1:0] EV_HOLD_ONCE = 3'd3;
  localparam logic [KIND_W-1:0] EV_HOLD      = 3'd4;

  typedef struct packed {
    logic load;       // latch the scan
    logic commit;     // update current button, queue its first event
    logic emit_hold;  // queue the hold that follows a hold-once
    logic flush;      // push the queued event out as the last of the scan
  } cmd_t;

  typedef struct packed {
    logic ev_any;     // current button produces at least one event
    logic ev_two;     // current button produces hold-once plus hold
    logic out_free;   // output register can take an item this cycle
    logic pend_valid; // an event waits in the pending slot
  } sts_t;

endpackage

FILE: rtl/bphr_ctrl.sv
// ----------------------------------------------------------------------------
// bphr_ctrl
// Sequencer: walks a scan's buttons, one per cycle unless an output stall or
// a hold-once pair holds it, and issues commit/hold/flush to the datapath.
// ----------------------------------------------------------------------------
module bphr_ctrl #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT_DEF,
  parameter int ACTIVE       = (BUTTON_COUNT < bphr_pkg::LEVEL_BITS) ?
                               BUTTON_COUNT : bphr_pkg::LEVEL_BITS,
  parameter int IW           = (ACTIVE > 1) ? $clog2(ACTIVE) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bphr_pkg::sts_t  sts_i,
  output bphr_pkg::cmd_t  cmd_o,
  output logic [IW-1:0]   idx_o
);
  import bphr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_HOLD2 = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          emit_ok;
  logic          last_btn;

  assign emit_ok  = !sts_i.pend_valid || sts_i.out_free;
  assign last_btn = (idx_q == IW'(ACTIVE - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts_i.ev_any || emit_ok) begin
          cmd_o.commit = sts_i.ev_any;
          if (sts_i.ev_any && sts_i.ev_two) begin
            state_d = ST_HOLD2;
          end else if (last_btn) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_HOLD2: begin
        if (emit_ok) begin
          cmd_o.emit_hold = 1'b1;
          if (last_btn) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EVAL;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_o      = idx_q;

endmodule

FILE: rtl/bphr_datapath.sv
// ----------------------------------------------------------------------------
// bphr_datapath
// Per-button state, configuration registers, event decision for the current
// button, one pending event slot and the output register.
// ----------------------------------------------------------------------------
module bphr_datapath #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT_DEF,
  parameter int ACTIVE       = (BUTTON_COUNT < bphr_pkg::LEVEL_BITS) ?
                               BUTTON_COUNT : bphr_pkg::LEVEL_BITS,
  parameter int IW           = (ACTIVE > 1) ? $clog2(ACTIVE) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bphr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bphr_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [bphr_pkg::TIME_W-1:0]       time_ms_i,
  input  logic [bphr_pkg::LEVEL_BITS-1:0]   levels_low_i,
  input  bphr_pkg::cmd_t                    cmd_i,
  input  logic [IW-1:0]                     idx_i,
  output bphr_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bphr_pkg::KIND_W-1:0]       event_kind_o,
  output logic [bphr_pkg::BTN_W-1:0]        button_index_o,
  output logic                              last_event_o
);
  import bphr_pkg::*;

  logic [CFG_W-1:0]  debounce_q, hold_thr_q, repeat_q;
  logic [TIME_W-1:0] now_q;
  logic [ACTIVE-1:0] levels_q;

  logic [ACTIVE-1:0] pressed_q, hold_sent_q;
  logic [TIME_W-1:0] press_time_q  [ACTIVE];
  logic [TIME_W-1:0] last_edge_q   [ACTIVE];
  logic [TIME_W-1:0] last_repeat_q [ACTIVE];

  logic              pend_valid_q;
  logic [KIND_W-1:0] pend_kind_q;
  logic [BTN_W-1:0]  pend_btn_q;

  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] out_kind_q;
  logic [BTN_W-1:0]  out_btn_q;
  logic              out_last_q;

  logic              low, was, hs;
  logic [TIME_W-1:0] d_edge, d_press, d_rep;
  logic              press_c, rel_c, hold1_c, rep_c;
  logic [KIND_W-1:0] first_kind, new_kind;
  logic              queue_ev;
  logic              out_free;

  // event decision for the current button
  assign low     = levels_q[idx_i];
  assign was     = pressed_q[idx_i];
  assign hs      = hold_sent_q[idx_i];
  assign d_edge  = now_q - last_edge_q[idx_i];
  assign d_press = now_q - press_time_q[idx_i];
  assign d_rep   = now_q - last_repeat_q[idx_i];

  assign press_c = low && !was && (d_edge > TIME_W'(debounce_q));
  assign rel_c   = !low && was;
  assign hold1_c = low && was && !hs && (d_press > TIME_W'(hold_thr_q));
  assign rep_c   = low && was && hs && (d_rep >= TIME_W'(repeat_q));

  always_comb begin
    if (press_c) begin
      first_kind = EV_PRESS;
    end else if (rel_c) begin
      first_kind = hs ? EV_RELEASE : EV_CLICK;
    end else if (hold1_c) begin
      first_kind = EV_HOLD_ONCE;
    end else begin
      first_kind = EV_HOLD;
    end
  end

  assign queue_ev = cmd_i.commit || cmd_i.emit_hold;
  assign new_kind = cmd_i.emit_hold ? EV_HOLD : first_kind;
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.ev_any     = press_c || rel_c || hold1_c || rep_c;
  assign sts_o.ev_two     = hold1_c;
  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      hold_thr_q <= HOLD_THR_RST;
      repeat_q   <= REPEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_HOLD_THR: hold_thr_q <= cfg_data_i;
        REG_REPEAT:   repeat_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q    <= time_ms_i;
      levels_q <= levels_low_i[ACTIVE-1:0];
    end
  end

  // button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q   <= '0;
      hold_sent_q <= '0;
      for (int i = 0; i < ACTIVE; i++) begin
        press_time_q[i]  <= '0;
        last_edge_q[i]   <= '0;
        last_repeat_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (press_c) begin
        pressed_q[idx_i]    <= 1'b1;
        hold_sent_q[idx_i]  <= 1'b0;
        press_time_q[idx_i] <= now_q;
        last_edge_q[idx_i]  <= now_q;
      end else if (rel_c) begin
        pressed_q[idx_i]   <= 1'b0;
        hold_sent_q[idx_i] <= 1'b0;
        last_edge_q[idx_i] <= now_q;
      end else begin
        // hold-once or repeat
        hold_sent_q[idx_i]   <= 1'b1;
        last_repeat_q[idx_i] <= now_q;
      end
    end
  end

  // one-deep pending slot: an event goes out only once we know whether
  // another one follows it in the same scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (queue_ev) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (queue_ev) begin
      pend_kind_q <= new_kind;
      pend_btn_q  <= BTN_W'(idx_i);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((queue_ev && pend_valid_q) || cmd_i.flush) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((queue_ev && pend_valid_q) || cmd_i.flush) begin
      out_kind_q <= pend_kind_q;
      out_btn_q  <= pend_btn_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign button_index_o = out_btn_q;
  assign last_event_o   = out_last_q;

endmodule

FILE: rtl/button_press_hold_repeat.sv
// ----------------------------------------------------------------------------
// button_press_hold_repeat
// Debounced press, click/release, hold-once, hold and auto-repeat events from
// periodic scans of active-low button levels.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_stall_o   time_ms_i[31:0], levels_low_i[5:0]
//  out      out_valid_o / out_stall_i event_kind_o[2:0], button_index_o[2:0],
//                                     last_event_o
//  cfg      cfg_we_i                  cfg_idx_i[1:0], cfg_data_i[15:0]
//
// A scan is accepted in the idle state, then the button sequencer evaluates
// each scanned button (min of BUTTON_COUNT and 6) in turn, adds a HOLD2 step
// per hold-once pair and ends in a flush state; a new scan waits until idle.
// Output stalls hold the sequencer only when an event must be pushed.
// Reset clears all button state and loads the default thresholds.
// ----------------------------------------------------------------------------
module button_press_hold_repeat #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bphr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bphr_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bphr_pkg::TIME_W-1:0]     time_ms_i,
  input  logic [bphr_pkg::LEVEL_BITS-1:0] levels_low_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bphr_pkg::KIND_W-1:0]     event_kind_o,
  output logic [bphr_pkg::BTN_W-1:0]      button_index_o,
  output logic                            last_event_o
);
  import bphr_pkg::*;

  localparam int ACTIVE = (BUTTON_COUNT < LEVEL_BITS) ? BUTTON_COUNT : LEVEL_BITS;
  localparam int IW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] idx;

  bphr_ctrl #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .ACTIVE       (ACTIVE),
    .IW           (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  bphr_datapath #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .ACTIVE       (ACTIVE),
    .IW           (IW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .time_ms_i      (time_ms_i),
    .levels_low_i   (levels_low_i),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .button_index_o (button_index_o),
    .last_event_o   (last_event_o)
  );

endmodule

FILE: tb/bphr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphr_checker
// Watches the scan and event channels of the button event generator. It keeps
// its own copy of per-button state and thresholds, predicts the events that
// each scan causes, and checks every event that leaves the block, in order.
// ----------------------------------------------------------------------------
module bphr_checker #(
  parameter int BUTTON_COUNT = bphr_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bphr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bphr_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [bphr_pkg::TIME_W-1:0]     time_ms_i,
  input  logic [bphr_pkg::LEVEL_BITS-1:0] levels_low_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [bphr_pkg::KIND_W-1:0]     event_kind_i,
  input  logic [bphr_pkg::BTN_W-1:0]      button_index_i,
  input  logic                            last_event_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              events_o
);
  import bphr_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BTN_W-1:0]  btn;
    logic              last;
  } btn_event_t;

  btn_event_t        expected_q[$];
  btn_event_t        head;
  int                fails;
  int                checked;

  logic [CFG_W-1:0]  deb_lim_ms;
  logic [CFG_W-1:0]  hold_thr_ms;
  logic [CFG_W-1:0]  repeat_ms;

  logic              pressed   [BUTTON_COUNT];
  logic              hold_sent [BUTTON_COUNT];
  logic [TIME_W-1:0] press_t   [BUTTON_COUNT];
  logic [TIME_W-1:0] edge_t    [BUTTON_COUNT];
  logic [TIME_W-1:0] repeat_t  [BUTTON_COUNT];

  task automatic push_event(input logic [KIND_W-1:0] kind, input int b);
    btn_event_t ev;
    ev.kind = kind;
    ev.btn  = b[BTN_W-1:0];
    ev.last = 1'b0;
    expected_q.push_back(ev);
  endtask

  // walk the buttons in index order, updating state as the block would
  task automatic predict_scan(input logic [TIME_W-1:0] now,
                              input logic [LEVEL_BITS-1:0] lv);
    int                first;
    logic              low;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_repeat;
    first = expected_q.size();
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      low          = (i < LEVEL_BITS) ? lv[i] : 1'b0;
      since_edge   = now - edge_t[i];
      since_press  = now - press_t[i];
      since_repeat = now - repeat_t[i];
      if (low && !pressed[i] && since_edge > TIME_W'(deb_lim_ms)) begin
        pressed[i]   = 1'b1;
        hold_sent[i] = 1'b0;
        press_t[i]   = now;
        edge_t[i]    = now;
        push_event(EV_PRESS, i);
      end else if (!low && pressed[i]) begin
        // releases are taken on the first high scan, no debounce
        pressed[i] = 1'b0;
        edge_t[i]  = now;
        push_event(hold_sent[i] ? EV_RELEASE : EV_CLICK, i);
        hold_sent[i] = 1'b0;
      end else if (low && pressed[i] && !hold_sent[i]) begin
        if (since_press > TIME_W'(hold_thr_ms)) begin
          hold_sent[i] = 1'b1;
          repeat_t[i]  = now;
          push_event(EV_HOLD_ONCE, i);
          push_event(EV_HOLD, i);
        end
      end else if (low && pressed[i]) begin
        if (since_repeat >= TIME_W'(repeat_ms)) begin
          repeat_t[i] = now;
          push_event(EV_HOLD, i);
        end
      end
    end
    if (expected_q.size() > first)
      expected_q[expected_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_lim_ms  = DEBOUNCE_RST;
      hold_thr_ms = HOLD_THR_RST;
      repeat_ms   = REPEAT_RST;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        pressed[i]   = 1'b0;
        hold_sent[i] = 1'b0;
        press_t[i]   = '0;
        edge_t[i]    = '0;
        repeat_t[i]  = '0;
      end
      expected_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE: deb_lim_ms  = cfg_data_i;
          REG_HOLD_THR: hold_thr_ms = cfg_data_i;
          REG_REPEAT:   repeat_ms   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        predict_scan(time_ms_i, levels_low_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected event: event_kind %0d button_index %0d last_event %0d",
                 event_kind_i, button_index_i, last_event_i);
          fails++;
        end else begin
          head = expected_q.pop_front();
          checked++;
          if (event_kind_i !== head.kind) begin
            $error("event_kind mismatch: expected %0d, got %0d", head.kind, event_kind_i);
            fails++;
          end
          if (button_index_i !== head.btn) begin
            $error("button_index mismatch: expected %0d, got %0d",
                   head.btn, button_index_i);
            fails++;
          end
          if (last_event_i !== head.last) begin
            $error("last_event mismatch: expected %0d, got %0d", head.last, last_event_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    events_o     <= checked;
  end

endmodule

FILE: tb/tb_button_press_hold_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_hold_repeat
// Drives scans into the button event generator: a directed walk through
// debounce, click, hold, repeat, release and timestamp wrap, then random
// scan sequences under several threshold settings and flow-control mixes.
// ----------------------------------------------------------------------------
module tb_button_press_hold_repeat;
  import bphr_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 6;
  localparam int SCANS_PER_PHASE = 67;
  // index past the last register, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [TIME_W-1:0]     time_ms_i    = '0;
  logic [LEVEL_BITS-1:0] levels_low_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [KIND_W-1:0]     event_kind_o;
  logic [BTN_W-1:0]      button_index_o;
  logic                  last_event_o;

  int                    fail_count;
  int                    pending;
  int                    events_checked;
  int                    cycles        = 0;
  int                    scans_sent    = 0;
  int                    in_idle_pct   = 0;
  int                    out_stall_pct = 0;
  int                    step_max      = 64;
  logic [TIME_W-1:0]     scan_time;
  logic [LEVEL_BITS-1:0] scan_levels;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  button_press_hold_repeat u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .time_ms_i      (time_ms_i),
    .levels_low_i   (levels_low_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .button_index_o (button_index_o),
    .last_event_o   (last_event_o)
  );

  bphr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .time_ms_i      (time_ms_i),
    .levels_low_i   (levels_low_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_i   (event_kind_o),
    .button_index_i (button_index_o),
    .last_event_i   (last_event_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .events_o       (events_checked)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_pace(input int mode);
    case (mode)
      0: begin
        in_idle_pct   = 10;
        out_stall_pct = 49;
      end
      1: begin
        in_idle_pct   = 49;
        out_stall_pct = 10;
      end
      default: begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
    endcase
  endtask

  // valid stays high between back-to-back items; only a gap lowers it
  task automatic send_scan(input logic [TIME_W-1:0] t, input logic [LEVEL_BITS-1:0] lv);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    time_ms_i    <= t;
    levels_low_i <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scans_sent++;
  endtask

  // scans may leave no event behind, so allow a full scan time after the queue empties
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                                 input logic [CFG_W-1:0] rep, input bit poke_unused);
    int top_ms;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_HOLD_THR, hold);
    write_reg(REG_REPEAT, rep);
    if (poke_unused)
      write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
    top_ms = deb;
    if (hold > top_ms) top_ms = hold;
    if (rep > top_ms) top_ms = rep;
    // time steps scaled so thresholds get crossed within a few scans
    step_max = top_ms / 4 + 3;
  endtask

  task automatic random_scans(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        scan_time = $urandom;
      end else begin
        scan_time = scan_time + $urandom_range(0, step_max);
        if (pick < 12) begin
          scan_levels = LEVEL_BITS'($urandom_range(0, 63));
        end else begin
          for (int b = 0; b < LEVEL_BITS; b++)
            if ($urandom_range(0, 7) == 0) scan_levels[b] = ~scan_levels[b];
        end
      end
      send_scan(scan_time, scan_levels);
    end
  endtask

  initial begin
    set_pace(0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: debounce 50, hold 500, repeat 100
    send_scan(32'd0, 6'h3F);           // quiet, inside debounce
    send_scan(32'd50, 6'h3F);          // debounce boundary, still no press
    send_scan(32'd51, 6'h3F);          // all six pressed
    send_scan(32'd551, 6'h3F);         // hold boundary, nothing yet
    send_scan(32'd552, 6'h2A);         // clicks on even, hold pairs on odd
    send_scan(32'd602, 6'h3F);         // even buttons bounce back too early
    send_scan(32'd603, 6'h3F);         // even buttons pressed again
    send_scan(32'd652, 6'h3F);         // repeat exactly at the interval
    send_scan(32'd751, 6'h15);         // odd buttons released after hold
    send_scan(32'd752, 6'h3F);         // re-press blocked by debounce
    send_scan(32'hFFFF_FFC0, 6'h3F);
    send_scan(32'h0000_01B5, 6'h3F);   // hold across the timestamp wrap
    send_scan(32'h0000_0219, 6'h3F);   // repeat on all six
    send_scan(32'hFFFF_FFFF, 6'h00);   // time runs backwards, all released
    send_scan(32'h0000_0040, 6'h3F);
    send_scan(32'h0000_0300, 6'h3F);   // twelve events from one scan
    send_scan(32'h0000_0300, 6'h3F);   // same timestamp, quiet
    send_scan(32'h0000_0400, 6'h00);
    drain;

    scan_time   = $urandom;
    scan_levels = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_pace(p / 2);
      case (p)
        0: load_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
        1: load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        2: load_thresholds(CFG_W'($urandom_range(0, 100)),
                           CFG_W'($urandom_range(0, 400)),
                           CFG_W'($urandom_range(1, 100)), 1'b1);
        3: load_thresholds(DEBOUNCE_RST, HOLD_THR_RST, REPEAT_RST, 1'b0);
        4: load_thresholds(CFG_W'($urandom_range(0, 2000)),
                           CFG_W'($urandom_range(0, 5000)),
                           CFG_W'($urandom_range(1, 1000)), 1'b1);
        default: load_thresholds(16'd1, 16'd1, 16'd1, 1'b0);
      endcase
      random_scans(SCANS_PER_PHASE);
      drain;
    end

    $display("Covered %0d scans under %0d threshold settings and three pacing mixes,",
             scans_sent, RANDOM_PHASES + 1);
    $display("with %0d events compared against the predicted sequence.", events_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
